FILE: src/cross_entropy_loss_accumulator_macros.svh
// assertion macros shared by the checker of the loss accumulator
// depends on nothing; take in by include
`ifndef CROSS_ENTROPY_LOSS_ACCUMULATOR_MACROS_SVH
`define CROSS_ENTROPY_LOSS_ACCUMULATOR_MACROS_SVH

// implication into the next cycle, switched off while reset is high
`define CELA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication into the next cycle that also holds through reset
`define CELA_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cela_pkg.sv
// types, constants and the log table of the loss accumulator
// depends on nothing
package cela_pkg;

   localparam int MAX_ROWS_DEF  = 65536;
   localparam int FRAC_BITS_DEF = 15;

   localparam int SUM_W   = 48;
   localparam int NL_W    = 28;
   localparam int TERM_W  = NL_W + 16 - 15;
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   localparam logic [27:0] LN2_Q24 = 28'd11629080;

   typedef struct packed {
      logic [15:0] predicted_prob;
      logic [15:0] target_weight;
      logic        row_end;
      logic        set_end;
   } req_type;

   typedef struct packed {
      logic [31:0] mean_loss;
      logic        overflow_flag;
   } rsp_type;

   typedef struct packed {
      logic [TERM_W-1:0] term;
      logic              row_end;
      logic              set_end;
   } term_type;

   typedef enum logic [1:0] {
      BK_ACCUM,
      BK_DIVIDE,
      BK_DELIVER
   } back_state_type;

   // ln(1 + k/16) in q.24
   function automatic logic [23:0] ln_tab(input logic [4:0] k);
      logic [23:0] v;
      case (k)
         5'd0:    v = 24'd0;
         5'd1:    v = 24'd1017112;
         5'd2:    v = 24'd1976071;
         5'd3:    v = 24'd2883169;
         5'd4:    v = 24'd3743728;
         5'd5:    v = 24'd4562291;
         5'd6:    v = 24'd5342767;
         5'd7:    v = 24'd6088544;
         5'd8:    v = 24'd6802576;
         5'd9:    v = 24'd7487455;
         5'd10:   v = 24'd8145470;
         5'd11:   v = 24'd8778647;
         5'd12:   v = 24'd9388795;
         5'd13:   v = 24'd9977530;
         5'd14:   v = 24'd10546303;
         5'd15:   v = 24'd11096425;
         5'd16:   v = 24'd11629080;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/cela_front.sv
// front end: clamps the prediction, takes its negated log and weights it
// depends on cela_pkg
module cela_front #(
   parameter int FRAC_BITS = cela_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cela_pkg::req_type req,
   output logic              push,
   input  logic              full,
   output cela_pkg::term_type push_data
);
   import cela_pkg::*;

   localparam int DN = 24 - FRAC_BITS;

   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic        en1, en2, en3;
   logic [14:0] p;
   logic [3:0]  e;
   logic [29:0] shifted;
   logic [4:0]  k;
   logic [23:0] t_lo, t_hi;

   logic [23:0] s1_t0_ff;
   logic [19:0] s1_dif_ff;
   logic [10:0] s1_r_ff;
   logic [27:0] s1_base_ff;
   logic [15:0] s1_tw_ff;
   logic        s1_re_ff, s1_se_ff;

   logic [23:0] s2_t0_ff;
   logic [30:0] s2_prod_ff;
   logic [27:0] s2_base_ff;
   logic [15:0] s2_tw_ff;
   logic        s2_re_ff, s2_se_ff;

   logic [NL_W-1:0] s3_nl_ff;
   logic [15:0]     s3_tw_ff;
   logic            s3_re_ff, s3_se_ff;

   logic [27:0]       lnm, nlog;
   logic [NL_W+15:0]  wprod;

   assign en3 = !v3_ff || !full;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // clamp, leading one and table lookup
   always_comb begin
      if (req.predicted_prob == 16'd0) begin
         p = 15'd1;
      end else if (req.predicted_prob > 16'd32767) begin
         p = 15'd32767;
      end else begin
         p = req.predicted_prob[14:0];
      end
      e = 4'd0;
      for (int i = 1; i < 15; i++) begin
         if (p[i]) begin
            e = 4'(i);
         end
      end
      shifted = {15'd0, p} << (4'd15 - e);
      k    = {1'b0, shifted[14:11]};
      t_lo = ln_tab(k);
      t_hi = ln_tab(k + 5'd1);
   end

   always_comb begin
      lnm   = {4'd0, s2_t0_ff} + {8'd0, s2_prod_ff[30:11]};
      nlog  = (s2_base_ff - lnm) >> DN;
      wprod = s3_nl_ff * s3_tw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_t0_ff   <= t_lo;
         s1_dif_ff  <= 20'(t_hi - t_lo);
         s1_r_ff    <= shifted[10:0];
         s1_base_ff <= 28'({24'd0, 4'd15 - e} * LN2_Q24);
         s1_tw_ff   <= req.target_weight;
         s1_re_ff   <= req.row_end;
         s1_se_ff   <= req.set_end;
      end
      if (en2) begin
         s2_t0_ff   <= s1_t0_ff;
         s2_prod_ff <= s1_dif_ff * s1_r_ff;
         s2_base_ff <= s1_base_ff;
         s2_tw_ff   <= s1_tw_ff;
         s2_re_ff   <= s1_re_ff;
         s2_se_ff   <= s1_se_ff;
      end
      if (en3) begin
         s3_nl_ff <= NL_W'(nlog);
         s3_tw_ff <= s2_tw_ff;
         s3_re_ff <= s2_re_ff;
         s3_se_ff <= s2_se_ff;
      end
   end

   assign push              = v3_ff && !full;
   assign push_data.term    = wprod[NL_W+15:15];
   assign push_data.row_end = s3_re_ff;
   assign push_data.set_end = s3_se_ff;

endmodule

FILE: src/cela_queue.sv
// short queue of weighted terms between front and back
// depends on cela_pkg
module cela_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cela_pkg::term_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                avail,
   output cela_pkg::term_type  pop_data
);
   import cela_pkg::*;

   term_type          slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_AW:0]     cnt_ff, cnt_in;

   assign full     = cnt_ff == (Q_AW+1)'(Q_DEPTH);
   assign avail    = cnt_ff != '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: src/cela_back.sv
// back end: saturating accumulate, row count and serial mean division
// depends on cela_pkg
module cela_back #(
   parameter int MAX_ROWS  = cela_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = cela_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               avail,
   input  cela_pkg::term_type pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cela_pkg::rsp_type  rsp
);
   import cela_pkg::*;

   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int UP   = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
   localparam int DN   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int DIVW = SUM_W + UP;
   localparam int CW   = $clog2(DIVW + 1);

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [RW-1:0]    rows_ff, rows_in;
   logic             sat_ff, sat_in;
   logic [SUM_W:0]   sum_add;

   logic [DIVW-1:0]  dq_ff;
   logic [RW:0]      rem_ff;
   logic [RW-1:0]    dvs_ff;
   logic             dsat_ff;
   logic [CW-1:0]    cnt_ff;
   logic [RW:0]      rem_sh, rem_sub;
   logic             q_bit;
   logic [DIVW-1:0]  mean_full;

   logic             out_v_ff;
   rsp_type          out_ff;

   logic take, start, div_done, load_out;

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_ACCUM: begin
            if (avail && pop_data.set_end) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (cnt_ff == CW'(1)) begin
               state_in = BK_DELIVER;
            end
         end
         BK_DELIVER: begin
            if (!out_v_ff || !rsp_stall) begin
               state_in = BK_ACCUM;
            end
         end
         default: state_in = BK_ACCUM;
      endcase
   end

   always_comb begin
      take     = 1'b0;
      div_done = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_ACCUM:   take = avail;
         BK_DIVIDE:  div_done = 1'b0;
         BK_DELIVER: load_out = !out_v_ff || !rsp_stall;
         default:    take = 1'b0;
      endcase
   end

   assign pop   = take;
   assign start = take && pop_data.set_end;

   // saturating accumulate and row count for the popped item
   always_comb begin
      sum_add = {1'b0, sum_ff} + (SUM_W+1)'(pop_data.term);
      sum_in  = sum_ff;
      rows_in = rows_ff;
      sat_in  = sat_ff;
      if (take) begin
         if (sum_add[SUM_W]) begin
            sum_in = '1;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_add[SUM_W-1:0];
         end
         if (pop_data.row_end || pop_data.set_end) begin
            if (rows_ff != RW'(MAX_ROWS)) begin
               rows_in = rows_ff + 1'b1;
            end else begin
               sat_in = 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff[RW-1:0], dq_ff[DIVW-1]};
      q_bit   = rem_sh >= {1'b0, dvs_ff};
      rem_sub = q_bit ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      mean_full = dq_ff >> DN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_ACCUM;
         sum_ff   <= '0;
         rows_ff  <= '0;
         sat_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (start) begin
            sum_ff  <= '0;
            rows_ff <= '0;
            sat_ff  <= 1'b0;
            cnt_ff  <= CW'(DIVW);
         end else begin
            sum_ff  <= sum_in;
            rows_ff <= rows_in;
            sat_ff  <= sat_in;
            if (state_ff == BK_DIVIDE && !div_done) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         if (load_out) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff   <= DIVW'(sum_in) << UP;
         rem_ff  <= '0;
         dvs_ff  <= rows_in;
         dsat_ff <= sat_in;
      end else if (state_ff == BK_DIVIDE) begin
         dq_ff  <= {dq_ff[DIVW-2:0], q_bit};
         rem_ff <= rem_sub;
      end
      if (load_out) begin
         if (mean_full > DIVW'(32'hFFFF_FFFF)) begin
            out_ff.mean_loss     <= 32'hFFFF_FFFF;
            out_ff.overflow_flag <= 1'b1;
         end else begin
            out_ff.mean_loss     <= mean_full[31:0];
            out_ff.overflow_flag <= dsat_ff;
         end
      end
   end

endmodule

FILE: src/cross_entropy_loss_accumulator.sv
// top level of the cross-entropy loss accumulator
// depends on cela_pkg, cela_front, cela_queue and cela_back
//
//   port group  dir  payload   meaning
//   req_*       in   req_type  prediction, target weight, row and set marks
//   rsp_*       out  rsp_type  mean loss in q16.16 and overflow flag
//
// the front, unless stalled, takes one item a cycle into a three-stage log
// and weight pipe; a four-entry term queue sits between front and back
// the back adds one term a cycle while accumulating; a set end starts a
// restoring divide forming 48 + (16 - FRAC_BITS, if positive) quotient
// bits one at a time, and pops nothing more until the mean is in the output register
// reset is synchronous and clears sums, counts, pipe and queue occupancy
// either side may stall; the queue and output register hold items meanwhile
module cross_entropy_loss_accumulator #(
   parameter int MAX_ROWS  = cela_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = cela_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cela_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cela_pkg::rsp_type rsp
);
   import cela_pkg::*;

   // terms travelling from front to back
   logic     push, full, pop, avail;
   term_type push_data, pop_data;

   cela_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .push     (push),
      .full     (full),
      .push_data(push_data)
   );

   cela_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .pop      (pop),
      .avail    (avail),
      .pop_data (pop_data)
   );

   // accumulate, count rows, divide at set end
   cela_back #(
      .MAX_ROWS (MAX_ROWS),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (avail),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

endmodule

FILE: src/cela_checker.sv
// port-level checks of the loss accumulator, bound to the top level
// depends on cela_pkg and the macro header
`include "cross_entropy_loss_accumulator_macros.svh"

module cela_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input cela_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cela_pkg::rsp_type rsp
);
   import cela_pkg::*;

   // a stalled result holds
   `CELA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

   // reset leaves no result pending
   `CELA_ASSERT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "result after reset")

   // front is free right after reset
   `CELA_ASSERT_ALWAYS(a_req_reset, clock, reset, !req_stall, "input stalled after reset")

   // a stalled item is held by the sender
   `CELA_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req), "stalled item changed")

endmodule

bind cross_entropy_loss_accumulator cela_port_checks u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req      (req),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp      (rsp)
);
